// ===== hw/rtl/wta_pkg.sv =====
// Shared types and constants of the weekly alarm table.
package wta_pkg;

   localparam int ID_W     = 16;
   localparam int DATE_W   = 22;
   localparam int YEAR_SCALE  = 10000;
   localparam int MONTH_SCALE = 100;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_ADD       = 3'd1,
      MODE_UPDATE    = 3'd2,
      MODE_DELETE    = 3'd3,
      MODE_SET_EN    = 3'd4,
      MODE_QUERY_EN  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic {
      KIND_FIRED = 1'b0,
      KIND_DONE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_FIRE,
      WR_UPDATE,
      WR_ENABLE,
      WR_ADD,
      WR_SHIFT
   } wr_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [7:0]        target;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [6:0]        mask;
      logic [7:0]        command;
      logic              enable;
      logic [DATE_W-1:0] fired_date;
   } entry_type;

   typedef struct packed {
      logic   capture;
      logic   idx_inc;
      logic   rd_en;
      wr_type wr_kind;
      logic   mark_found;
      logic   add_entry;
      logic   set_full;
      logic   dec_count;
      logic   emit_fire;
      logic   emit_done;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       idx_end;
      logic       table_full;
      logic       fire_hit;
      logic       id_hit;
   } stat_type;

endpackage

// ===== hw/rtl/wta_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module wta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/wta_ctrl.sv =====
// Controller state machine of the weekly alarm table.
module wta_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  wta_pkg::stat_type  stat,
   output wta_pkg::cmd_type   cmd,
   output logic               busy
);

   wta_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wta_pkg::ST_IDLE: begin
            if (start) state_in = wta_pkg::ST_DISPATCH;
         end
         wta_pkg::ST_DISPATCH: begin
            case (stat.mode) inside
               wta_pkg::MODE_TICK, wta_pkg::MODE_UPDATE, wta_pkg::MODE_DELETE,
               wta_pkg::MODE_SET_EN, wta_pkg::MODE_QUERY_EN:
                  state_in = wta_pkg::ST_SCAN_RD;
               wta_pkg::MODE_ADD:
                  state_in = wta_pkg::ST_ADD;
               default:
                  state_in = wta_pkg::ST_DONE;
            endcase
         end
         wta_pkg::ST_SCAN_RD: begin
            state_in = stat.idx_end ? wta_pkg::ST_DONE : wta_pkg::ST_SCAN_EV;
         end
         wta_pkg::ST_SCAN_EV: begin
            if (stat.mode == wta_pkg::MODE_TICK || !stat.id_hit) begin
               state_in = wta_pkg::ST_SCAN_RD;
            end else if (stat.mode == wta_pkg::MODE_DELETE) begin
               state_in = wta_pkg::ST_SHIFT_RD;
            end else begin
               state_in = wta_pkg::ST_DONE;
            end
         end
         wta_pkg::ST_SHIFT_RD: begin
            state_in = stat.idx_end ? wta_pkg::ST_DONE : wta_pkg::ST_SHIFT_WR;
         end
         wta_pkg::ST_SHIFT_WR: state_in = wta_pkg::ST_SHIFT_RD;
         wta_pkg::ST_ADD:      state_in = wta_pkg::ST_DONE;
         wta_pkg::ST_DONE:     state_in = wta_pkg::ST_IDLE;
         default:              state_in = wta_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      cmd.wr_kind = wta_pkg::WR_NONE;
      unique case (state_ff)
         wta_pkg::ST_IDLE: begin
            cmd.capture = start;
         end
         wta_pkg::ST_DISPATCH: begin
         end
         wta_pkg::ST_SCAN_RD: begin
            cmd.rd_en = !stat.idx_end;
         end
         wta_pkg::ST_SCAN_EV: begin
            if (stat.mode == wta_pkg::MODE_TICK) begin
               cmd.idx_inc = 1'b1;
               if (stat.fire_hit) begin
                  cmd.wr_kind   = wta_pkg::WR_FIRE;
                  cmd.emit_fire = 1'b1;
               end
            end else if (stat.id_hit) begin
               cmd.mark_found = 1'b1;
               case (stat.mode)
                  wta_pkg::MODE_UPDATE: cmd.wr_kind = wta_pkg::WR_UPDATE;
                  wta_pkg::MODE_SET_EN: cmd.wr_kind = wta_pkg::WR_ENABLE;
                  wta_pkg::MODE_DELETE: cmd.idx_inc = 1'b1;
                  default:              cmd.wr_kind = wta_pkg::WR_NONE;
               endcase
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         wta_pkg::ST_SHIFT_RD: begin
            cmd.rd_en     = !stat.idx_end;
            cmd.dec_count = stat.idx_end;
         end
         wta_pkg::ST_SHIFT_WR: begin
            cmd.wr_kind = wta_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
         end
         wta_pkg::ST_ADD: begin
            if (stat.table_full) begin
               cmd.set_full = 1'b1;
            end else begin
               cmd.add_entry = 1'b1;
               cmd.wr_kind   = wta_pkg::WR_ADD;
            end
         end
         wta_pkg::ST_DONE: begin
            cmd.emit_done = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != wta_pkg::ST_IDLE);

endmodule

// ===== hw/rtl/wta_datapath.sv =====
// Datapath of the weekly alarm table: entry memory, counters and result registers.
module wta_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  wta_pkg::cmd_type  cmd,
   output wta_pkg::stat_type stat,
   input  logic [2:0]        req_mode,
   input  logic [15:0]       req_entry_id,
   input  logic [7:0]        req_target_id,
   input  logic [4:0]        req_hour,
   input  logic [5:0]        req_minute,
   input  logic [6:0]        req_weekday_mask,
   input  logic [7:0]        req_command_code,
   input  logic              req_enable_flag,
   input  logic [7:0]        req_year,
   input  logic [3:0]        req_month,
   input  logic [4:0]        req_day_of_month,
   input  logic [2:0]        req_weekday,
   output logic              rsp_strobe,
   output logic              rsp_result_kind,
   output logic [1:0]        rsp_status,
   output logic [15:0]       rsp_result_id,
   output logic [7:0]        rsp_fired_target,
   output logic [7:0]        rsp_fired_command,
   output logic              rsp_enabled_out,
   output logic              rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = wta_pkg::DATE_W;
   localparam int EW = $bits(wta_pkg::entry_type);

   // Captured item.
   logic [2:0]  mode_ff;
   logic [15:0] id_ff;
   logic [7:0]  target_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [6:0]  mask_ff;
   logic [7:0]  command_ff;
   logic        enable_ff;
   logic [2:0]  weekday_ff;
   logic [DW-1:0] today_ff;

   // Table bookkeeping.
   logic [CW-1:0] count_ff;
   logic [15:0]   next_id_ff;
   logic [CW-1:0] idx_ff;
   logic [1:0]    status_ff;
   logic [15:0]   result_id_ff;
   logic          found_en_ff;

   // Result registers.
   logic        strobe_ff;
   logic        kind_ff;
   logic [1:0]  out_status_ff;
   logic [15:0] out_id_ff;
   logic [7:0]  out_target_ff;
   logic [7:0]  out_command_ff;
   logic        out_en_ff;
   logic        out_last_ff;

   wta_pkg::entry_type rd_entry;
   wta_pkg::entry_type wr_entry;
   logic [EW-1:0]      rdata;
   logic               we;
   logic [AW-1:0]      waddr;
   logic [CW-1:0]      idx_prev;
   logic [7:0]         mask_ext;
   logic [DW-1:0]      today_in;

   assign rd_entry = wta_pkg::entry_type'(rdata);
   assign idx_prev = idx_ff - CW'(1);
   assign mask_ext = {1'b0, rd_entry.mask};

   assign today_in = DW'(req_year) * DW'(wta_pkg::YEAR_SCALE)
                   + DW'(req_month) * DW'(wta_pkg::MONTH_SCALE)
                   + DW'(req_day_of_month);

   assign stat.mode       = mode_ff;
   assign stat.idx_end    = (idx_ff >= count_ff);
   assign stat.table_full = (count_ff >= CW'(TABLE_DEPTH));
   assign stat.id_hit     = (rd_entry.id == id_ff);
   assign stat.fire_hit   = rd_entry.enable && mask_ext[weekday_ff]
                          && (rd_entry.hour == hour_ff) && (rd_entry.minute == minute_ff)
                          && (rd_entry.fired_date != today_ff);

   // Write port data and address.
   always_comb begin
      wr_entry = rd_entry;
      waddr    = idx_ff[AW-1:0];
      we       = 1'b1;
      unique case (cmd.wr_kind) inside
         wta_pkg::WR_NONE: we = 1'b0;
         wta_pkg::WR_FIRE: wr_entry.fired_date = today_ff;
         wta_pkg::WR_UPDATE, wta_pkg::WR_ADD: begin
            wr_entry.target     = target_ff;
            wr_entry.hour       = hour_ff;
            wr_entry.minute     = minute_ff;
            wr_entry.mask       = mask_ff;
            wr_entry.command    = command_ff;
            wr_entry.enable     = enable_ff;
            wr_entry.fired_date = '0;
            if (cmd.wr_kind == wta_pkg::WR_ADD) begin
               wr_entry.id = next_id_ff;
               waddr       = count_ff[AW-1:0];
            end
         end
         wta_pkg::WR_ENABLE: wr_entry.enable = enable_ff;
         wta_pkg::WR_SHIFT:  waddr = idx_prev[AW-1:0];
         default:            we = 1'b0;
      endcase
   end

   wta_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (EW'(wr_entry)),
      .re    (cmd.rd_en),
      .raddr (idx_ff[AW-1:0]),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_mode;
         id_ff      <= req_entry_id;
         target_ff  <= req_target_id;
         hour_ff    <= req_hour;
         minute_ff  <= req_minute;
         mask_ff    <= req_weekday_mask;
         command_ff <= req_command_code;
         enable_ff  <= req_enable_flag;
         weekday_ff <= req_weekday;
         today_ff   <= today_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         next_id_ff <= 16'd1;
      end else begin
         if (cmd.add_entry) begin
            count_ff   <= count_ff + CW'(1);
            next_id_ff <= (next_id_ff == 16'hFFFF) ? 16'd1 : next_id_ff + 16'd1;
         end else if (cmd.dec_count) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff       <= '0;
         result_id_ff <= '0;
         found_en_ff  <= 1'b0;
         case (req_mode) inside
            wta_pkg::MODE_UPDATE, wta_pkg::MODE_DELETE, wta_pkg::MODE_SET_EN,
            wta_pkg::MODE_QUERY_EN:
               status_ff <= wta_pkg::STATUS_NOT_FOUND;
            default:
               status_ff <= wta_pkg::STATUS_OK;
         endcase
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.mark_found) begin
            status_ff   <= wta_pkg::STATUS_OK;
            found_en_ff <= (mode_ff == wta_pkg::MODE_QUERY_EN) && rd_entry.enable;
         end
         if (cmd.set_full) begin
            status_ff <= wta_pkg::STATUS_FULL;
         end
         if (cmd.add_entry) begin
            result_id_ff <= next_id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_fire || cmd.emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fire) begin
         kind_ff        <= wta_pkg::KIND_FIRED;
         out_status_ff  <= wta_pkg::STATUS_OK;
         out_id_ff      <= rd_entry.id;
         out_target_ff  <= rd_entry.target;
         out_command_ff <= rd_entry.command;
         out_en_ff      <= 1'b0;
         out_last_ff    <= 1'b0;
      end else if (cmd.emit_done) begin
         kind_ff        <= wta_pkg::KIND_DONE;
         out_status_ff  <= status_ff;
         out_id_ff      <= result_id_ff;
         out_target_ff  <= '0;
         out_command_ff <= '0;
         out_en_ff      <= found_en_ff;
         out_last_ff    <= 1'b1;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_result_id     = out_id_ff;
   assign rsp_fired_target  = out_target_ff;
   assign rsp_fired_command = out_command_ff;
   assign rsp_enabled_out   = out_en_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== hw/rtl/weekly_alarm_table.sv =====
// Top level of the weekly alarm table: controller plus datapath.
//
//   Channel    Handshake            Direction  Contents
//   request    start, busy          in         req_mode .. req_weekday, one item
//   response   rsp_strobe           out        rsp_result_kind .. rsp_last
//
// An item is taken at a rising edge with start high and busy low. Busy then stays high
// through the dispatch and done states (unused modes), also through the add state (add),
// or also through a scan of the N stored entries: a scan reads and compares each entry,
// an id hit ends it early, and a delete reads each later entry and moves it down by one.
// Reset clears the entry count and sets the next id to one; the entry memory is not cleared.
// Results cannot be stalled and show for one cycle with rsp_strobe high; the done item
// (rsp_last high) comes in the first cycle with busy low, when the next item may be taken.
module weekly_alarm_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_entry_id,
   input  logic [7:0]  req_target_id,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [6:0]  req_weekday_mask,
   input  logic [7:0]  req_command_code,
   input  logic        req_enable_flag,
   input  logic [7:0]  req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day_of_month,
   input  logic [2:0]  req_weekday,
   output logic        rsp_strobe,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_id,
   output logic [7:0]  rsp_fired_target,
   output logic [7:0]  rsp_fired_command,
   output logic        rsp_enabled_out,
   output logic        rsp_last
);

   // The controller sequences the scan and shift passes; the datapath holds
   // the table and reports the compare results back as status.
   wta_pkg::cmd_type  cmd;
   wta_pkg::stat_type stat;

   wta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   wta_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_entry_id      (req_entry_id),
      .req_target_id     (req_target_id),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_weekday_mask  (req_weekday_mask),
      .req_command_code  (req_command_code),
      .req_enable_flag   (req_enable_flag),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day_of_month  (req_day_of_month),
      .req_weekday       (req_weekday),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_fired_target  (rsp_fired_target),
      .rsp_fired_command (rsp_fired_command),
      .rsp_enabled_out   (rsp_enabled_out),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hw/rtl/wta_checker.sv =====
// Port-level checks of the weekly alarm table and their bind.
module wta_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_result_kind,
   input logic [1:0] rsp_status,
   input logic       rsp_enabled_out,
   input logic       rsp_last
);

   // Only the done item closes an item.
   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last == (rsp_result_kind == wta_pkg::KIND_DONE)))
      else $error("last flag and result kind disagree");

   // A fired item carries no status and no enable answer.
   a_fired_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == wta_pkg::KIND_FIRED)
         |-> (rsp_status == wta_pkg::STATUS_OK && !rsp_enabled_out))
      else $error("fired item with status or enable set");

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Fired items appear while the scan runs; the done item after it has ended.
   a_fired_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("fired item outside a scan");

   a_done_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("done item while still busy");

endmodule

bind weekly_alarm_table wta_checker u_wta_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_result_kind (rsp_result_kind),
   .rsp_status      (rsp_status),
   .rsp_enabled_out (rsp_enabled_out),
   .rsp_last        (rsp_last)
);
